// ===== rtl/core/quadratic_root_solver_assert.svh =====
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define QRS_ASSERT_IMP(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("quadratic_root_solver assertion failed");
// next-cycle implication
`define QRS_ASSERT_NXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("quadratic_root_solver assertion failed");
`else
`define QRS_ASSERT_IMP(label, clock, rst_n, ante, cons)
`define QRS_ASSERT_NXT(label, clock, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, codes and payload types shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_W    = 16;
	localparam int ROOT_W    = 32;
	localparam int ROOT_FRAC = ROOT_W / 2;
	localparam int GUARD_RAW = (61 - 2 * COEF_W) / 2;
	localparam int GUARD     = (GUARD_RAW < ROOT_FRAC) ? GUARD_RAW : ROOT_FRAC;
	localparam int TSHIFT    = ROOT_FRAC - GUARD;

	// discriminant and its magnitude
	localparam int D_W    = 2 * COEF_W + 2;
	localparam int DMAG_W = 2 * COEF_W + 1;

	// square root: radicand |d| * 2^(2G), padded to an even width
	localparam int SQ_IN_W = DMAG_W + 2 * GUARD;
	localparam int SQ_W    = (SQ_IN_W + 1) / 2;

	// -b * 2^G and 2a
	localparam int NB_W  = COEF_W + GUARD + 1;
	localparam int DEN_W = COEF_W + 1;

	// numerator magnitudes and divider widths
	localparam int MX_W   = (((COEF_W - 1 + GUARD) > SQ_W) ? (COEF_W - 1 + GUARD) : SQ_W) + 1;
	localparam int NMAG_W = MX_W + TSHIFT;
	localparam int QN_W   = NMAG_W + 2;
	localparam int QD_W   = DEN_W + 1;

	typedef enum logic [1:0] {
		KIND_TWO_REAL = 2'd0,
		KIND_DOUBLE   = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_DEGEN    = 2'd3
	} kind_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
	} qrs_in_t;

	typedef struct packed {
		logic signed [ROOT_W-1:0] root1_real;
		logic signed [ROOT_W-1:0] root1_imag;
		logic signed [ROOT_W-1:0] root2_real;
		logic signed [ROOT_W-1:0] root2_imag;
		logic [1:0]               root_kind;
		logic                     saturated;
	} qrs_out_t;

	// classified item passed from front to back
	typedef struct packed {
		kind_t                    kind;
		logic [DMAG_W-1:0]        dmag;
		logic signed [NB_W-1:0]   nb;
		logic signed [DEN_W-1:0]  den;
	} qrs_job_t;

endpackage

// ===== rtl/core/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficient sets, forms the discriminant, classifies the roots and
// queues the job for the back end.
// ----------------------------------------------------------------------------
module qrs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qrs_pkg::qrs_in_t  coefs,
	output logic              job_valid,
	output qrs_pkg::qrs_job_t job
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	logic                                  accept;
	logic                                  valid_s1;
	logic signed [qrs_pkg::COEF_W-1:0]     a_s1;
	logic signed [qrs_pkg::COEF_W-1:0]     b_s1;
	logic signed [2*qrs_pkg::COEF_W-1:0]   bb_s1;
	logic signed [2*qrs_pkg::COEF_W-1:0]   ac_s1;
	logic signed [qrs_pkg::D_W-1:0]        disc;
	qrs_pkg::qrs_job_t                     job_new;
	qrs_pkg::qrs_job_t                     queue_q [QDEPTH];
	logic [PTR_W-1:0]                      wr_ptr_q;
	logic [PTR_W-1:0]                      rd_ptr_q;
	logic [CNT_W-1:0]                      count_q;
	logic                                  push;
	logic                                  pop;

	assign accept = start && !busy;
	assign busy   = (count_q == CNT_W'(QDEPTH));

	// capture the products of the accepted set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1  <= coefs.coef_a;
			b_s1  <= coefs.coef_b;
			bb_s1 <= (2 * qrs_pkg::COEF_W)'(coefs.coef_b) *
				(2 * qrs_pkg::COEF_W)'(coefs.coef_b);
			ac_s1 <= (2 * qrs_pkg::COEF_W)'(coefs.coef_a) *
				(2 * qrs_pkg::COEF_W)'(coefs.coef_c);
		end
	end

	// discriminant and classification
	always_comb begin
		disc         = qrs_pkg::D_W'(bb_s1) - (qrs_pkg::D_W'(ac_s1) <<< 2);
		job_new.dmag = qrs_pkg::DMAG_W'((disc < 0) ? -disc : disc);
		job_new.nb   = -(qrs_pkg::NB_W'(b_s1)) <<< qrs_pkg::GUARD;
		job_new.den  = qrs_pkg::DEN_W'(a_s1) <<< 1;
		priority if (a_s1 == '0) begin
			job_new.kind = qrs_pkg::KIND_DEGEN;
		end else if (disc > 0) begin
			job_new.kind = qrs_pkg::KIND_TWO_REAL;
		end else if (disc == 0) begin
			job_new.kind = qrs_pkg::KIND_DOUBLE;
		end else begin
			job_new.kind = qrs_pkg::KIND_COMPLEX;
		end
	end

	// job queue; the back end drains one entry per cycle
	assign push      = valid_s1;
	assign pop       = (count_q != '0);
	assign job_valid = pop;
	assign job       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= job_new;
		end
	end

endmodule

// ===== rtl/core/qrs_isqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module qrs_isqrt #(
	parameter int OUT_W  = 31,
	parameter int SIDE_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [2*OUT_W-1:0]   in_x,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic [OUT_W-1:0]     out_root,
	output logic [SIDE_W-1:0]    out_side
);

	localparam int IN_W = 2 * OUT_W;
	localparam int RW   = OUT_W + 2;

	logic [OUT_W-1:0]  vld_q;
	logic [IN_W-1:0]   x_q    [OUT_W];
	logic [RW-1:0]     rem_q  [OUT_W];
	logic [OUT_W-1:0]  root_q [OUT_W];
	logic [SIDE_W-1:0] side_q [OUT_W];

	for (genvar i = 0; i < OUT_W; i++) begin : g_stage
		logic              cv;
		logic [IN_W-1:0]   cx;
		logic [RW-1:0]     crem;
		logic [OUT_W-1:0]  croot;
		logic [SIDE_W-1:0] cside;
		logic [RW-1:0]     remsh;
		logic [RW-1:0]     trial;

		if (i == 0) begin : g_first
			assign cv    = in_valid;
			assign cx    = in_x;
			assign crem  = '0;
			assign croot = '0;
			assign cside = in_side;
		end else begin : g_next
			assign cv    = vld_q[i-1];
			assign cx    = x_q[i-1];
			assign crem  = rem_q[i-1];
			assign croot = root_q[i-1];
			assign cside = side_q[i-1];
		end

		// bring down the next two radicand bits and try the next root bit
		assign remsh = {crem[RW-3:0], cx[IN_W-1 -: 2]};
		assign trial = {croot, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else begin
				vld_q[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			x_q[i]    <= cx << 2;
			side_q[i] <= cside;
			if (remsh >= trial) begin
				rem_q[i]  <= remsh - trial;
				root_q[i] <= {croot[OUT_W-2:0], 1'b1};
			end else begin
				rem_q[i]  <= remsh;
				root_q[i] <= {croot[OUT_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_q[OUT_W-1];
	assign out_root  = root_q[OUT_W-1];
	assign out_side  = side_q[OUT_W-1];

endmodule

// ===== rtl/core/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, several numerator
// lanes sharing one divisor.
// ----------------------------------------------------------------------------
module qrs_div #(
	parameter int N_W    = 36,
	parameter int D_W    = 18,
	parameter int LANES  = 3,
	parameter int SIDE_W = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [LANES-1:0][N_W-1:0]   in_num,
	input  logic [D_W-1:0]              in_den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [LANES-1:0][N_W-1:0]   out_quo,
	output logic [SIDE_W-1:0]           out_side
);

	logic [N_W-1:0]                  vld_q;
	logic [LANES-1:0][N_W-1:0]       num_q  [N_W];
	logic [LANES-1:0][D_W-1:0]       rem_q  [N_W];
	logic [LANES-1:0][N_W-1:0]       quo_q  [N_W];
	logic [D_W-1:0]                  den_q  [N_W];
	logic [SIDE_W-1:0]               side_q [N_W];

	for (genvar i = 0; i < N_W; i++) begin : g_stage
		logic                        cv;
		logic [LANES-1:0][N_W-1:0]   cnum;
		logic [LANES-1:0][D_W-1:0]   crem;
		logic [LANES-1:0][N_W-1:0]   cquo;
		logic [D_W-1:0]              cden;
		logic [SIDE_W-1:0]           cside;
		logic [LANES-1:0][D_W-1:0]   rem_n;
		logic [LANES-1:0][N_W-1:0]   quo_n;

		if (i == 0) begin : g_first
			assign cv    = in_valid;
			assign cnum  = in_num;
			assign crem  = '0;
			assign cquo  = '0;
			assign cden  = in_den;
			assign cside = in_side;
		end else begin : g_next
			assign cv    = vld_q[i-1];
			assign cnum  = num_q[i-1];
			assign crem  = rem_q[i-1];
			assign cquo  = quo_q[i-1];
			assign cden  = den_q[i-1];
			assign cside = side_q[i-1];
		end

		// shift in one dividend bit per lane, subtract when it fits
		always_comb begin
			logic [D_W:0] remsh;
			logic [D_W:0] diff;
			for (int l = 0; l < LANES; l++) begin
				remsh = {crem[l], cnum[l][N_W-1]};
				diff  = remsh - {1'b0, cden};
				if (remsh >= {1'b0, cden}) begin
					rem_n[l] = diff[D_W-1:0];
					quo_n[l] = {cquo[l][N_W-2:0], 1'b1};
				end else begin
					rem_n[l] = remsh[D_W-1:0];
					quo_n[l] = {cquo[l][N_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else begin
				vld_q[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < LANES; l++) begin
				num_q[i][l] <= cnum[l] << 1;
			end
			rem_q[i]  <= rem_n;
			quo_q[i]  <= quo_n;
			den_q[i]  <= cden;
			side_q[i] <= cside;
		end
	end

	assign out_valid = vld_q[N_W-1];
	assign out_quo   = quo_q[N_W-1];
	assign out_side  = side_q[N_W-1];

endmodule

// ===== rtl/core/qrs_back.sv =====
// ----------------------------------------------------------------------------
// qrs_back
// Takes classified jobs, runs the square root and the rounded divisions and
// registers the saturated roots.
// ----------------------------------------------------------------------------
module qrs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  qrs_pkg::qrs_job_t job,
	output logic              done,
	output qrs_pkg::qrs_out_t roots
);

	localparam int X_W    = 2 * qrs_pkg::SQ_W;
	localparam int SQS_W  = 2 + qrs_pkg::NB_W + qrs_pkg::DEN_W;
	localparam int DVS_W  = 4;
	localparam int RES_W  = qrs_pkg::ROOT_W + 1;
	localparam int QN_W   = qrs_pkg::QN_W;
	localparam logic [QN_W-1:0] POS_MAX = QN_W'((65'(1) << (qrs_pkg::ROOT_W - 1)) - 65'(1));
	localparam logic [QN_W-1:0] NEG_MAG = QN_W'(65'(1) << (qrs_pkg::ROOT_W - 1));

	// clip a rounded magnitude to the root range and apply its sign
	function automatic logic [RES_W-1:0] sat_root(input logic [QN_W-1:0] q, input logic neg);
		logic [qrs_pkg::ROOT_W-1:0] val;
		logic                       sat;
		sat = 1'b0;
		if (neg && (q != '0)) begin
			if (q > NEG_MAG) begin
				val = NEG_MAG[qrs_pkg::ROOT_W-1:0];
				sat = 1'b1;
			end else begin
				val = -q[qrs_pkg::ROOT_W-1:0];
			end
		end else begin
			if (q > POS_MAX) begin
				val = POS_MAX[qrs_pkg::ROOT_W-1:0];
				sat = 1'b1;
			end else begin
				val = q[qrs_pkg::ROOT_W-1:0];
			end
		end
		return {sat, val};
	endfunction

	logic                                 sq_valid;
	logic [qrs_pkg::SQ_W-1:0]             sq_root;
	logic [SQS_W-1:0]                     sq_side;
	qrs_pkg::kind_t                       sq_kind;
	logic signed [qrs_pkg::NB_W-1:0]      sq_nb;
	logic signed [qrs_pkg::DEN_W-1:0]     sq_den;
	logic signed [qrs_pkg::MX_W:0]        nbx;
	logic signed [qrs_pkg::MX_W:0]        sx;

	logic                                 valid_s1;
	qrs_pkg::kind_t                       kind_s1;
	logic signed [qrs_pkg::MX_W:0]        n1_s1;
	logic signed [qrs_pkg::MX_W:0]        n2_s1;
	logic [qrs_pkg::SQ_W-1:0]             sq_s1;
	logic [qrs_pkg::DEN_W-1:0]            mden_s1;
	logic                                 nden_s1;

	logic [qrs_pkg::MX_W-1:0]             mag1;
	logic [qrs_pkg::MX_W-1:0]             mag2;
	logic [2:0][QN_W-1:0]                 dv_num;
	logic [qrs_pkg::QD_W-1:0]             dv_den;
	logic [DVS_W-1:0]                     dv_side;

	logic                                 q_valid;
	logic [2:0][QN_W-1:0]                 q_quo;
	logic [DVS_W-1:0]                     q_side;
	qrs_pkg::kind_t                       q_kind;
	logic [RES_W-1:0]                     r1;
	logic [RES_W-1:0]                     r2;
	logic [RES_W-1:0]                     ri;
	qrs_pkg::qrs_out_t                    res;

	logic                                 done_q;
	qrs_pkg::qrs_out_t                    roots_q;

	// square root of |d| with guard bits
	qrs_isqrt #(
		.OUT_W  (qrs_pkg::SQ_W),
		.SIDE_W (SQS_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_valid),
		.in_x      (X_W'(job.dmag) << (2 * qrs_pkg::GUARD)),
		.in_side   ({job.kind, job.nb, job.den}),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	assign sq_kind = qrs_pkg::kind_t'(sq_side[SQS_W-1 -: 2]);
	assign sq_nb   = sq_side[qrs_pkg::DEN_W +: qrs_pkg::NB_W];
	assign sq_den  = sq_side[0 +: qrs_pkg::DEN_W];
	assign nbx     = (qrs_pkg::MX_W + 1)'(sq_nb);
	assign sx      = $signed((qrs_pkg::MX_W + 1)'(sq_root));

	// form the signed numerators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= sq_kind;
		sq_s1   <= sq_root;
		nden_s1 <= (sq_den < 0);
		mden_s1 <= qrs_pkg::DEN_W'((sq_den < 0) ? -sq_den : sq_den);
		if (sq_kind == qrs_pkg::KIND_TWO_REAL) begin
			n1_s1 <= nbx + sx;
			n2_s1 <= nbx - sx;
		end else begin
			n1_s1 <= nbx;
			n2_s1 <= nbx;
		end
	end

	// rounded quotient (2|n|*2^TSHIFT + |den|) / (2|den|)
	always_comb begin
		mag1 = qrs_pkg::MX_W'((n1_s1 < 0) ? -n1_s1 : n1_s1);
		mag2 = qrs_pkg::MX_W'((n2_s1 < 0) ? -n2_s1 : n2_s1);
		dv_num[0] = ((QN_W'(mag1) << qrs_pkg::TSHIFT) << 1) + QN_W'(mden_s1);
		dv_num[1] = ((QN_W'(mag2) << qrs_pkg::TSHIFT) << 1) + QN_W'(mden_s1);
		dv_num[2] = ((QN_W'(sq_s1) << qrs_pkg::TSHIFT) << 1) + QN_W'(mden_s1);
		dv_den    = qrs_pkg::QD_W'(mden_s1) << 1;
		dv_side   = {kind_s1, (n1_s1 < 0) ^ nden_s1, (n2_s1 < 0) ^ nden_s1};
	end

	qrs_div #(
		.N_W    (QN_W),
		.D_W    (qrs_pkg::QD_W),
		.LANES  (3),
		.SIDE_W (DVS_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_num    (dv_num),
		.in_den    (dv_den),
		.in_side   (dv_side),
		.out_valid (q_valid),
		.out_quo   (q_quo),
		.out_side  (q_side)
	);

	// saturate and assemble the result
	always_comb begin
		q_kind = qrs_pkg::kind_t'(q_side[3:2]);
		r1     = sat_root(q_quo[0], q_side[1]);
		r2     = sat_root(q_quo[1], q_side[0]);
		ri     = sat_root(q_quo[2], 1'b0);
		res    = '0;
		res.root_kind = q_kind;
		unique case (q_kind)
			qrs_pkg::KIND_TWO_REAL: begin
				res.root1_real = r1[qrs_pkg::ROOT_W-1:0];
				res.root2_real = r2[qrs_pkg::ROOT_W-1:0];
				res.saturated  = r1[qrs_pkg::ROOT_W] | r2[qrs_pkg::ROOT_W];
			end
			qrs_pkg::KIND_DOUBLE: begin
				res.root1_real = r1[qrs_pkg::ROOT_W-1:0];
				res.root2_real = r1[qrs_pkg::ROOT_W-1:0];
				res.saturated  = r1[qrs_pkg::ROOT_W];
			end
			qrs_pkg::KIND_COMPLEX: begin
				res.root1_real = r1[qrs_pkg::ROOT_W-1:0];
				res.root2_real = r1[qrs_pkg::ROOT_W-1:0];
				res.root1_imag = ri[qrs_pkg::ROOT_W-1:0];
				res.root2_imag = -ri[qrs_pkg::ROOT_W-1:0];
				res.saturated  = r1[qrs_pkg::ROOT_W] | ri[qrs_pkg::ROOT_W];
			end
			qrs_pkg::KIND_DEGEN: begin
				res.saturated = 1'b0;
			end
			default: begin
				res.saturated = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		roots_q <= res;
	end

	assign done  = done_q;
	assign roots = roots_q;

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Both roots of a*x^2 + b*x + c = 0 from Q8.8 coefficients, in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Drive coefs and raise start; the set transfers on a rising edge with
//   start high and busy low. One result per set comes back on roots with
//   done high for exactly one cycle, in the order the sets went in.
//   root_kind: two real roots, double root, complex pair, or a equal to zero
//   (all root parts zero). saturated marks a root part clipped to range.
// Pipeline: with 16-bit coefficients a set passes the one-bit-per-stage square
//   root (31 stages) and the shared three-lane restoring divider (36 stages)
//   on its way from transfer to done.
// Throughput: one set per cycle; the front holds a two-entry job queue that
//   the back end drains every cycle, so busy does not rise in normal use.
// Reset: arst_n clears all valid flags and the queue; nothing is in flight.
// The receiver cannot stall; done is a pure strobe.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qrs_pkg::qrs_in_t  coefs,
	output logic              done,
	output qrs_pkg::qrs_out_t roots
);

	logic              job_valid;
	qrs_pkg::qrs_job_t job;

	// accept and classify
	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.coefs     (coefs),
		.job_valid (job_valid),
		.job       (job)
	);

	// solve
	qrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.done      (done),
		.roots     (roots)
	);

	`QRS_ASSERT_IMP(a_degen_zero, clk, arst_n, done && (roots.root_kind == qrs_pkg::KIND_DEGEN), (roots.root1_real == '0) && (roots.root2_real == '0) && (roots.root1_imag == '0) && (roots.root2_imag == '0) && !roots.saturated)
	`QRS_ASSERT_IMP(a_real_no_imag, clk, arst_n, done && ((roots.root_kind == qrs_pkg::KIND_TWO_REAL) || (roots.root_kind == qrs_pkg::KIND_DOUBLE)), (roots.root1_imag == '0) && (roots.root2_imag == '0))
	`QRS_ASSERT_IMP(a_pair_match, clk, arst_n, done && ((roots.root_kind == qrs_pkg::KIND_DOUBLE) || (roots.root_kind == qrs_pkg::KIND_COMPLEX)), roots.root1_real == roots.root2_real)
	`QRS_ASSERT_IMP(a_conj, clk, arst_n, done && (roots.root_kind == qrs_pkg::KIND_COMPLEX), !roots.root1_imag[qrs_pkg::ROOT_W-1] && (roots.root2_imag == -roots.root1_imag))

endmodule
